@@ hdl/l1sf_pkg.sv @@
// Package for the L1 scale fit grid search: types, constants and register indexes.
package l1sf_pkg;

  localparam int MAX_PAIRS_DEF = 256;
  localparam int VAL_W         = 24;
  localparam int COUNT_W       = 17;
  localparam int INDEX_W       = 16;
  localparam int COST_W        = 48;
  localparam int FRAC_DROP     = 20;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_START = 2'd3;

  localparam logic signed [VAL_W-1:0] SCALE_START_RST  = -24'sd4194304;
  localparam logic signed [VAL_W-1:0] SCALE_STEP_RST   = 24'sd140;
  localparam logic [COUNT_W-1:0]      SCALE_COUNT_RST  = 17'd60000;
  localparam logic [INDEX_W-1:0]      SEARCH_START_RST = 16'd1;
  localparam logic [COUNT_W-1:0]      GRID_LIMIT       = 17'd65536;

  localparam logic signed [VAL_W-1:0] SCALE_MIN = -24'sd8388608;
  localparam logic signed [VAL_W-1:0] SCALE_MAX = 24'sd8388607;
  localparam logic [COST_W-1:0]       COST_MAX  = {COST_W{1'b1}};

  typedef struct packed {
    logic signed [VAL_W-1:0] measured;
    logic signed [VAL_W-1:0] template_value;
    logic                    last_sample;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]      best_index;
    logic signed [VAL_W-1:0] best_scale;
    logic [COST_W-1:0]       best_cost;
    logic [COST_W-1:0]       reference_cost;
  } out_item_t;

endpackage

@@ hdl/l1sf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module l1sf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/l1_scale_fit_grid_search_core.sv @@
// Top level: L1 scale fit by grid search over a stored set of residual/template pairs.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+---------------------------------
//  input    | start, busy, in_data           | transaction when start && !busy
//  result   | out_valid, out_data            | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_wdata   | write when cfg_we
//
// Each accepted transaction loads one pair. After the last pair the sweep visits
// 1 + max(0, count - first) grid points; each grid point takes one RAM read per pair,
// plus the scale multiply, the product pipeline drain and the compare.
// busy is high for the whole sweep. Reset clears control state only; the pair
// store needs no clearing pass. The result strobe cannot be stalled.
module l1_scale_fit_grid_search_core #(
  parameter int MAX_PAIRS = l1sf_pkg::MAX_PAIRS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  l1sf_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  output l1sf_pkg::out_item_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [l1sf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [l1sf_pkg::VAL_W-1:0]             cfg_wdata
);

  import l1sf_pkg::*;

  localparam int AW = $clog2(MAX_PAIRS);
  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int RW = 2 * VAL_W;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SCL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;

  logic [2:0]                state_r;
  logic signed [VAL_W-1:0]   scale_start_r;
  logic signed [VAL_W-1:0]   scale_step_r;
  logic [COUNT_W-1:0]        scale_count_r;
  logic [INDEX_W-1:0]        search_start_r;

  logic [CW-1:0]             pair_cnt_r;
  logic [CW-1:0]             rd_cnt_r;
  logic [COST_W-1:0]         base_r;
  logic [COST_W-1:0]         sum_r;
  logic [COST_W-1:0]         low_sum_r;
  logic [INDEX_W-1:0]        low_pos_r;
  logic signed [VAL_W-1:0]   low_scale_r;
  logic [COUNT_W-1:0]        grid_j_r;
  logic signed [41:0]        mul_r;
  logic signed [VAL_W-1:0]   scale_r;
  logic signed [2*VAL_W-1:0] prod_r;
  logic signed [VAL_W-1:0]   meas_r;
  logic                      v1_r;
  logic                      v2_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic                      accept;
  logic                      store_ok;
  logic                      issue;
  logic [RW-1:0]             rd_data;
  logic [VAL_W:0]            meas_abs;
  logic [COST_W:0]           base_add;
  logic signed [42:0]        raw_scale;
  logic signed [VAL_W-1:0]   sat_scale;
  logic signed [27:0]        prod_q;
  logic signed [28:0]        diff;
  logic [28:0]               diff_abs;
  logic [COST_W:0]           sum_add;
  logic [COUNT_W-1:0]        count_eff;
  logic [COUNT_W-1:0]        first_eff;
  logic [COUNT_W-1:0]        next_j;
  logic                      better;

  assign busy      = (state_r != S_LOAD);
  assign accept    = start && !busy;
  assign store_ok  = (pair_cnt_r < CW'(MAX_PAIRS));
  assign issue     = (state_r == S_ACC) && (rd_cnt_r < pair_cnt_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  l1sf_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_PAIRS)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_ok),
    .waddr (pair_cnt_r[AW-1:0]),
    .wdata ({in_data.measured, in_data.template_value}),
    .re    (issue),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    meas_abs = in_data.measured[VAL_W-1] ? (~{1'b1, in_data.measured} + (VAL_W+1)'(1))
                                         : {1'b0, in_data.measured};
    base_add = {1'b0, base_r} + (COST_W+1)'(meas_abs);
    raw_scale = $signed({mul_r[41], mul_r}) + 43'(scale_start_r);
    if (raw_scale < 43'(SCALE_MIN)) begin
      sat_scale = SCALE_MIN;
    end else if (raw_scale > 43'(SCALE_MAX)) begin
      sat_scale = SCALE_MAX;
    end else begin
      sat_scale = raw_scale[VAL_W-1:0];
    end
    prod_q   = prod_r[2*VAL_W-1:FRAC_DROP];
    diff     = 29'(meas_r) - 29'(prod_q);
    diff_abs = diff[28] ? 29'(-diff) : 29'(diff);
    sum_add  = {1'b0, sum_r} + (COST_W+1)'(diff_abs);
    if (scale_count_r == '0) begin
      count_eff = COUNT_W'(1);
    end else if (scale_count_r > GRID_LIMIT) begin
      count_eff = GRID_LIMIT;
    end else begin
      count_eff = scale_count_r;
    end
    first_eff = (search_start_r == '0) ? COUNT_W'(1) : COUNT_W'(search_start_r);
    next_j    = (grid_j_r == '0) ? first_eff : grid_j_r + COUNT_W'(1);
    better    = (grid_j_r == '0) || (sum_r < low_sum_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_start_r  <= SCALE_START_RST;
      scale_step_r   <= SCALE_STEP_RST;
      scale_count_r  <= SCALE_COUNT_RST;
      search_start_r <= SEARCH_START_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_START:  scale_start_r  <= cfg_wdata;
        REG_SCALE_STEP:   scale_step_r   <= cfg_wdata;
        REG_SCALE_COUNT:  scale_count_r  <= COUNT_W'(cfg_wdata);
        REG_SEARCH_START: search_start_r <= cfg_wdata[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= scale_r * $signed(rd_data[VAL_W-1:0]);
    meas_r <= $signed(rd_data[RW-1:VAL_W]);
    mul_r  <= $signed({1'b0, grid_j_r}) * scale_step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      pair_cnt_r  <= '0;
      rd_cnt_r    <= '0;
      base_r      <= '0;
      sum_r       <= '0;
      low_sum_r   <= '0;
      low_pos_r   <= '0;
      low_scale_r <= '0;
      grid_j_r    <= '0;
      scale_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      v1_r        <= issue;
      v2_r        <= v1_r;
      if (v2_r) begin
        sum_r <= sum_add[COST_W] ? COST_MAX : sum_add[COST_W-1:0];
      end
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              pair_cnt_r <= pair_cnt_r + CW'(1);
              base_r     <= base_add[COST_W] ? COST_MAX : base_add[COST_W-1:0];
            end
            if (in_data.last_sample) begin
              grid_j_r <= '0;
              state_r  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state_r <= S_SCL;
        end
        S_SCL: begin
          scale_r  <= sat_scale;
          rd_cnt_r <= '0;
          sum_r    <= '0;
          state_r  <= S_ACC;
        end
        S_ACC: begin
          if (issue) begin
            rd_cnt_r <= rd_cnt_r + CW'(1);
          end else if (!v1_r && !v2_r) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (better) begin
            low_sum_r   <= sum_r;
            low_pos_r   <= grid_j_r[INDEX_W-1:0];
            low_scale_r <= scale_r;
          end
          grid_j_r <= next_j;
          if (next_j >= count_eff) begin
            out_valid_r <= 1'b1;
            pair_cnt_r  <= '0;
            base_r      <= '0;
            state_r     <= S_LOAD;
          end else begin
            state_r <= S_MUL;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      out_data_r.reference_cost <= base_r;
      if (better) begin
        out_data_r.best_index <= grid_j_r[INDEX_W-1:0];
        out_data_r.best_scale <= scale_r;
        out_data_r.best_cost  <= sum_r;
      end else begin
        out_data_r.best_index <= low_pos_r;
        out_data_r.best_scale <= low_scale_r;
        out_data_r.best_cost  <= low_sum_r;
      end
    end
  end

endmodule

@@ tb/l1sf_fit_checker.sv @@
// Checker for the L1 scale fit core: watches the channels, predicts each fit and compares.
module l1sf_fit_checker #(
  parameter int MAX_PAIRS = l1sf_pkg::MAX_PAIRS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  l1sf_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  l1sf_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [l1sf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [l1sf_pkg::VAL_W-1:0]     cfg_wdata,
  output int unsigned                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import l1sf_pkg::*;

  logic signed [VAL_W-1:0] grid_start;
  logic signed [VAL_W-1:0] grid_step;
  logic [COUNT_W-1:0]      grid_count;
  logic [INDEX_W-1:0]      search_from;

  logic signed [VAL_W-1:0] load_measured[$];
  logic signed [VAL_W-1:0] load_template[$];
  out_item_t               fits_due[$];
  out_item_t               want_fit;
  int unsigned             mismatch_count = 0;
  int unsigned             fits_pending = 0;

  assign fail_count = mismatch_count + fits_pending;

  function automatic logic signed [VAL_W-1:0] scale_at(input int unsigned j);
    longint s;
    s = longint'(grid_start) + longint'(j) * longint'(grid_step);
    if (s < longint'(SCALE_MIN)) s = longint'(SCALE_MIN);
    if (s > longint'(SCALE_MAX)) s = longint'(SCALE_MAX);
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] deviation_sum(input logic signed [VAL_W-1:0] scale);
    longint unsigned sum;
    longint          p;
    longint          d;
    sum = 0;
    foreach (load_measured[i]) begin
      p = longint'(scale) * longint'(load_template[i]);
      d = longint'(load_measured[i]) - (p >>> FRAC_DROP);
      if (d < 0) d = -d;
      sum = sum + longint'(d);
      if (sum > COST_MAX) sum = COST_MAX;
    end
    return sum[COST_W-1:0];
  endfunction

  function automatic out_item_t fit_load();
    int unsigned        count;
    int unsigned        first;
    longint unsigned    base;
    longint             m;
    logic [COST_W-1:0]  low;
    logic [COST_W-1:0]  cost;
    logic [INDEX_W-1:0] low_idx;
    out_item_t          r;
    count = grid_count;
    if (count == 0) count = 1;
    if (count > GRID_LIMIT) count = GRID_LIMIT;
    first = search_from;
    if (first == 0) first = 1;
    base = 0;
    foreach (load_measured[i]) begin
      m = longint'(load_measured[i]);
      if (m < 0) m = -m;
      base = base + longint'(m);
      if (base > COST_MAX) base = COST_MAX;
    end
    low = deviation_sum(scale_at(0));
    low_idx = '0;
    for (int unsigned j = first; j < count; j++) begin
      cost = deviation_sum(scale_at(j));
      if (cost < low) begin
        low = cost;
        low_idx = j[INDEX_W-1:0];
      end
    end
    r.best_index     = low_idx;
    r.best_scale     = scale_at(low_idx);
    r.best_cost      = low;
    r.reference_cost = base[COST_W-1:0];
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    mismatch_count++;
    $display("%0t fit mismatch %s: expected %0h actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      grid_start  = SCALE_START_RST;
      grid_step   = SCALE_STEP_RST;
      grid_count  = SCALE_COUNT_RST;
      search_from = SEARCH_START_RST;
      load_measured.delete();
      load_template.delete();
      fits_due.delete();
    end else begin
      if (out_valid) begin
        if (fits_due.size() == 0) begin
          report("unexpected transaction", '0, 64'(out_data.best_cost));
        end else begin
          want_fit = fits_due.pop_front();
          if (out_data.best_index !== want_fit.best_index)
            report("best_index", 64'(want_fit.best_index), 64'(out_data.best_index));
          if (out_data.best_scale !== want_fit.best_scale)
            report("best_scale", 64'(want_fit.best_scale), 64'(out_data.best_scale));
          if (out_data.best_cost !== want_fit.best_cost)
            report("best_cost", 64'(want_fit.best_cost), 64'(out_data.best_cost));
          if (out_data.reference_cost !== want_fit.reference_cost)
            report("reference_cost", 64'(want_fit.reference_cost),
                   64'(out_data.reference_cost));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE_START:  grid_start  = cfg_wdata;
          REG_SCALE_STEP:   grid_step   = cfg_wdata;
          REG_SCALE_COUNT:  grid_count  = cfg_wdata[COUNT_W-1:0];
          REG_SEARCH_START: search_from = cfg_wdata[INDEX_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (load_measured.size() < MAX_PAIRS) begin
          load_measured.push_back(in_data.measured);
          load_template.push_back(in_data.template_value);
        end
        if (in_data.last_sample) begin
          fits_due.push_back(fit_load());
          load_measured.delete();
          load_template.delete();
        end
      end
    end
    fits_pending = fits_due.size();
  end

endmodule

@@ tb/tb_l1_scale_fit_grid_search_core.sv @@
// Testbench top for the L1 scale fit core: reset, register settings, pair loads and verdict.
module tb_l1_scale_fit_grid_search_core;
  timeunit 1ns;
  timeprecision 1ps;
  import l1sf_pkg::*;

  localparam int unsigned RUN_ITEMS   = 230;
  localparam int unsigned QUIET_TAIL  = 60;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned FULL_LOAD   = MAX_PAIRS_DEF + 2;
  localparam logic signed [VAL_W-1:0] SAMPLE_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAMPLE_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  in_item_t             in_data = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_wdata = '0;
  logic                 busy;
  logic                 out_valid;
  out_item_t            out_data;
  int unsigned          fail_count;

  int unsigned loads_sent = 0;
  int unsigned fits_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  longint cur_start;
  longint cur_step;
  int unsigned cur_count;

  always #5 clk = ~clk;

  l1_scale_fit_grid_search_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  l1sf_fit_checker fit_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) fits_seen <= fits_seen + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_pair(input logic signed [VAL_W-1:0] m, input logic signed [VAL_W-1:0] t,
                           input bit last);
    in_item_t item;
    item.measured       = m;
    item.template_value = t;
    item.last_sample    = last;
    in_data <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    if (last) loads_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (fits_seen < loads_sent || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_grid(input logic [VAL_W-1:0] v_start, input logic [VAL_W-1:0] v_step,
                          input logic [VAL_W-1:0] v_count, input logic [VAL_W-1:0] v_search);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [VAL_W-1:0]     val[4];
    idx = '{REG_SCALE_START, REG_SCALE_STEP, REG_SCALE_COUNT, REG_SEARCH_START};
    val = '{v_start, v_step, v_count, v_search};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_start = longint'($signed(v_start));
    cur_step  = longint'($signed(v_step));
    cur_count = (v_count[COUNT_W-1:0] == 0) ? 1 :
                (v_count[COUNT_W-1:0] > GRID_LIMIT) ? GRID_LIMIT : v_count[COUNT_W-1:0];
  endtask

  function automatic logic signed [VAL_W-1:0] rand_sample();
    int s;
    case ($urandom_range(0, 5))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: begin
        s = int'($urandom_range(0, 131071)) - 65536;
        return s[VAL_W-1:0];
      end
      default: return VAL_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned random_base;
    int unsigned n;
    int unsigned cnt;
    int unsigned srch;
    bit          fitted;
    longint      sc;
    longint      mv;
    logic signed [VAL_W-1:0] t;
    logic [VAL_W-1:0] w_start;
    logic [VAL_W-1:0] w_step;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // field extremes, then an all-tie load
    set_grid(-24'sd1048576, 24'sd65536, 24'd33, 24'd1);
    push_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    push_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    push_pair('0, '0, 1'b0);
    push_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    push_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    push_pair('0, '0, 1'b1);

    // zero count, zero search start
    wait_idle();
    set_grid(SAMPLE_MIN, SAMPLE_MAX, 24'd0, 24'd0);
    push_pair(rand_sample(), rand_sample(), 1'b0);
    push_pair(rand_sample(), rand_sample(), 1'b1);

    // scale saturates high
    wait_idle();
    set_grid(SAMPLE_MAX, SAMPLE_MAX, 24'd5, 24'd3);
    push_pair(rand_sample(), rand_sample(), 1'b0);
    push_pair(rand_sample(), rand_sample(), 1'b1);

    // scale saturates low, search start beyond count
    wait_idle();
    set_grid(SAMPLE_MIN, SAMPLE_MIN, 24'd4, 24'hFFFFFF);
    push_pair(VAL_W'($urandom), VAL_W'($urandom), 1'b1);

    // count above limit, only index 0 and the top index
    wait_idle();
    set_grid(24'd0, 24'd1, 24'hFFFFFF, 24'h00FFFF);
    push_pair(24'sd1000, 24'sd64000, 1'b1);

    // full grid size, late search start
    wait_idle();
    set_grid(SCALE_START_RST, SCALE_STEP_RST, 24'h010000, 24'd60000);
    push_pair(24'sd300000, 24'sd131072, 1'b0);
    push_pair(-24'sd5000, 24'sd70000, 1'b1);

    // store overflow: trailing pairs dropped, last mark still honored
    wait_idle();
    set_grid(-24'sd2097152, 24'sd1048576, 24'd3, 24'd1);
    for (int unsigned k = 1; k <= FULL_LOAD; k++)
      push_pair(rand_sample(), rand_sample(), k == FULL_LOAD);

    random_base = items_sent;
    while (items_sent - random_base < RUN_ITEMS) begin
      quiet = (items_sent - random_base) >= RUN_ITEMS - QUIET_TAIL;
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        w_start = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom)
                  : 24'(int'($urandom_range(0, 4194304)) - 2097152);
        case ($urandom_range(0, 3))
          0: w_step = VAL_W'($urandom);
          1: w_step = '0;
          default: w_step = 24'(int'($urandom_range(0, 8191)) - 4096);
        endcase
        case ($urandom_range(0, 5))
          0: begin
            cnt  = 0;
            srch = $urandom_range(0, 3);
          end
          1: begin
            cnt  = $urandom;
            srch = 65535 - $urandom_range(0, 6);
            if (cnt[COUNT_W-1:0] > srch + 8) cnt[COUNT_W-1:0] = GRID_LIMIT;
          end
          default: begin
            cnt  = $urandom_range(1, 48);
            srch = $urandom_range(0, cnt + 2);
          end
        endcase
        set_grid(w_start, w_step,
                 {7'($urandom_range(0, 127)), cnt[COUNT_W-1:0]},
                 {8'($urandom), srch[INDEX_W-1:0]});
      end
      n = $urandom_range(1, 8);
      fitted = $urandom_range(0, 2) != 0;
      sc = cur_start + longint'($urandom_range(0, cur_count - 1)) * cur_step;
      for (int unsigned k = 1; k <= n; k++) begin
        if (fitted) begin
          t  = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom)
               : 24'(int'($urandom_range(0, 1048576)) - 524288);
          mv = ((sc * longint'(t)) >>> FRAC_DROP) + longint'($urandom_range(0, 64)) - 32;
          push_pair(mv[VAL_W-1:0], t, k == n);
        end else begin
          push_pair(rand_sample(), rand_sample(), k == n);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
